/* src/lgcf_pkg.sv */
// Package: shared types, constants and helpers for the leg gait contact scheduler.
`timescale 1ns / 1ps
package lgcf_pkg;

  localparam int unsigned PatternDepth = 4;
  localparam int unsigned PatternLimit = (PatternDepth < 4) ? PatternDepth : 4;

  localparam logic [16:0] OneQ16    = 17'd65536;
  localparam logic [16:0] EarlyQ16  = 17'd58982;
  localparam logic [31:0] FloorZ    = 32'hFFFF_999A; // -26214, i.e. -0.4 m

  // Register indexes
  localparam logic [2:0] RegPhaseStep     = 3'd0;
  localparam logic [2:0] RegPatternLength = 3'd1;
  localparam logic [2:0] RegPatternStates = 3'd2;
  localparam logic [2:0] RegSwitchTime0   = 3'd3;
  localparam logic [2:0] RegSwitchTime1   = 3'd4;
  localparam logic [2:0] RegSwitchTime2   = 3'd5;
  localparam logic [2:0] RegSwitchTime3   = 3'd6;
  localparam logic [2:0] RegPushStep      = 3'd7;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic signed [31:0] foot_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic               contact;
  } req_t;

  typedef struct packed {
    logic               in_swing;
    logic [16:0]        progress;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               pushing_down;
    logic signed [31:0] lift_height;
    logic               predicted_swing;
    logic [17:0]        phase_out;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic restart;
    logic tick_a;
    logic div_start;
    logic tick_b;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mode;
    logic swing;
    logic div_done;
  } sts_t;

  // (idx + 1) mod len, len in 1..4
  function automatic logic [1:0] next_index(input logic [1:0] idx, input logic [2:0] len);
    logic [2:0] m;
    m = {1'b0, idx} + 3'd1;
    for (int k = 0; k < 4; k++) begin
      if (m >= len) m = m - len;
    end
    return m[1:0];
  endfunction

endpackage

/* src/lgcf_div.sv */
// Serial divider for the Q1.16 progress fraction, one quotient bit per cycle.
`timescale 1ns / 1ps
module lgcf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [18:0] num_i,
  input  logic signed [17:0] den_i,
  output logic               done_o,
  output logic [16:0]        quot_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d, ad_q, ad_d, quot_q, quot_d;
  logic [18:0] an;
  logic [17:0] ad;
  logic [17:0] sh;

  assign an = num_i[18] ? 19'(-num_i) : 19'(num_i);
  assign ad = den_i[17] ? 18'(-den_i) : 18'(den_i);
  assign sh = {rem_q, 1'b0};

  // Sort out the special cases at start, then shift and subtract
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    ad_d   = ad_q;
    quot_d = quot_q;
    if (start_i) begin
      done_d = 1'b0;
      busy_d = 1'b0;
      cnt_d  = '0;
      quot_d = '0;
      rem_d  = an[16:0];
      ad_d   = ad[16:0];
      if (den_i == '0) begin
        quot_d = lgcf_pkg::OneQ16;
        done_d = 1'b1;
      end else if (num_i == '0 || (num_i[18] != den_i[17])) begin
        done_d = 1'b1;
      end else if (an >= {1'b0, ad}) begin
        quot_d = lgcf_pkg::OneQ16;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (sh >= {1'b0, ad_q}) begin
        rem_d  = 17'(sh - {1'b0, ad_q});
        quot_d = {quot_q[15:0], 1'b1};
      end else begin
        rem_d  = sh[16:0];
        quot_d = {quot_q[15:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    ad_q   <= ad_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* src/lgcf_datapath.sv */
// Datapath: configuration, gait state, targets, prediction and result register.
`timescale 1ns / 1ps
module lgcf_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [16:0]      cfg_wdata_i,
  input  lgcf_pkg::req_t   req_i,
  input  lgcf_pkg::cmd_t   cmd_i,
  output lgcf_pkg::sts_t   sts_o,
  output lgcf_pkg::rsp_t   rsp_o
);

  // Configuration
  logic [16:0] phase_step_q;
  logic [2:0]  pat_len_q;
  logic [3:0]  pat_states_q;
  logic [16:0] sw_time_q [4];
  logic [15:0] push_step_q;

  // Gait state
  logic [17:0] phase_q, phase_d;
  logic        swing_q, swing_d, old_swing_q, old_swing_d;
  logic [1:0]  idx_q, idx_d;
  logic [16:0] start_q, start_d, end_q, end_d;
  logic        started_q, started_d, push_q, push_d;
  logic [31:0] held_q [3];
  logic [31:0] held_d [3];
  logic [31:0] goal_q [3];
  logic [31:0] goal_d [3];
  logic [31:0] lift_q, lift_d;
  lgcf_pkg::req_t req_q;
  lgcf_pkg::rsp_t rsp_q;

  logic [2:0]  eff_len;
  logic [16:0] eff_step;
  logic [17:0] phase_n, pred_p;
  logic [1:0]  seg_idx;
  logic        pred;
  logic        div_done;
  logic [16:0] quot;
  logic signed [18:0] num;
  logic signed [17:0] den;

  assign eff_len  = (pat_len_q == 3'd0) ? 3'd1 :
                    (pat_len_q > 3'(lgcf_pkg::PatternLimit)) ?
                    3'(lgcf_pkg::PatternLimit) : pat_len_q;
  assign eff_step = (phase_step_q > lgcf_pkg::OneQ16) ? lgcf_pkg::OneQ16 : phase_step_q;
  assign phase_n  = phase_q + {1'b0, eff_step};
  assign seg_idx  = lgcf_pkg::next_index(idx_q, eff_len);

  assign num = $signed({1'b0, phase_q}) - $signed({2'b0, start_q});
  assign den = $signed({1'b0, end_q}) - $signed({1'b0, start_q});

  lgcf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Predict the pattern state for the next tick
  always_comb begin
    logic found;
    found  = 1'b0;
    pred   = 1'b0;
    pred_p = phase_n;
    if (pred_p > {1'b0, lgcf_pkg::OneQ16}) pred_p = 18'(pred_p - {1'b0, lgcf_pkg::OneQ16});
    for (int i = 0; i < 4; i++) begin
      if (!found && 3'(i) < eff_len && pred_p <= {1'b0, sw_time_q[i]}) begin
        found = 1'b1;
        pred  = pat_states_q[i];
      end
    end
  end

  // Advance the gait state under controller commands
  always_comb begin
    logic [17:0] ph;
    phase_d     = phase_q;
    swing_d     = swing_q;
    old_swing_d = old_swing_q;
    idx_d       = idx_q;
    start_d     = start_q;
    end_d       = end_q;
    started_d   = started_q;
    push_d      = push_q;
    lift_d      = lift_q;
    held_d      = held_q;
    goal_d      = goal_q;
    ph          = phase_q;
    if (cmd_i.restart) begin
      phase_d   = '0;
      idx_d     = '0;
      start_d   = '0;
      end_d     = sw_time_q[0];
      if (swing_q) held_d = goal_q;
      swing_d   = pat_states_q[0];
      started_d = 1'b0;
      push_d    = 1'b0;
    end
    if (cmd_i.tick_a) begin
      if (!started_q) begin
        goal_d[0] = req_q.goal_x;
        goal_d[1] = req_q.goal_y;
        goal_d[2] = req_q.goal_z;
        held_d    = goal_d;
        started_d = 1'b1;
      end
      phase_d     = phase_n;
      old_swing_d = swing_q;
      push_d      = 1'b0;
      if (!swing_q && phase_n >= {1'b0, end_q}) begin
        lift_d  = req_q.foot_z;
        idx_d   = seg_idx;
        start_d = (phase_n > {1'b0, lgcf_pkg::OneQ16}) ?
                  17'(phase_n - {1'b0, lgcf_pkg::OneQ16}) : phase_n[16:0];
        end_d   = sw_time_q[seg_idx];
        swing_d = 1'b1;
      end
    end
    if (cmd_i.tick_b) begin
      if (old_swing_q &&
          ((quot > lgcf_pkg::EarlyQ16 && req_q.contact) || quot >= lgcf_pkg::OneQ16)) begin
        swing_d   = 1'b0;
        idx_d     = seg_idx;
        start_d   = (phase_q > {1'b0, lgcf_pkg::OneQ16}) ?
                    17'(phase_q - {1'b0, lgcf_pkg::OneQ16}) : phase_q[16:0];
        end_d     = sw_time_q[seg_idx];
        held_d[0] = req_q.foot_x;
        held_d[1] = req_q.foot_y;
        held_d[2] = req_q.foot_z;
      end
      if (ph > {1'b0, lgcf_pkg::OneQ16}) phase_d = '0;
      if (!swing_d) begin
        if (!req_q.contact && $signed(held_d[2]) > $signed(lgcf_pkg::FloorZ)) begin
          held_d[2] = held_d[2] - {16'b0, push_step_q};
          push_d    = 1'b1;
        end
      end else begin
        goal_d[0] = req_q.goal_x;
        goal_d[1] = req_q.goal_y;
        goal_d[2] = req_q.goal_z;
        held_d    = goal_d;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= 17'd328;
      pat_len_q    <= 3'd2;
      pat_states_q <= 4'd2;
      sw_time_q[0] <= 17'd32768;
      sw_time_q[1] <= lgcf_pkg::OneQ16;
      sw_time_q[2] <= lgcf_pkg::OneQ16;
      sw_time_q[3] <= lgcf_pkg::OneQ16;
      push_step_q  <= 16'd33;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lgcf_pkg::RegPhaseStep:     phase_step_q <= cfg_wdata_i;
        lgcf_pkg::RegPatternLength: pat_len_q    <= cfg_wdata_i[2:0];
        lgcf_pkg::RegPatternStates: pat_states_q <= cfg_wdata_i[3:0];
        lgcf_pkg::RegSwitchTime0:   sw_time_q[0] <= cfg_wdata_i;
        lgcf_pkg::RegSwitchTime1:   sw_time_q[1] <= cfg_wdata_i;
        lgcf_pkg::RegSwitchTime2:   sw_time_q[2] <= cfg_wdata_i;
        lgcf_pkg::RegSwitchTime3:   sw_time_q[3] <= cfg_wdata_i;
        lgcf_pkg::RegPushStep:      push_step_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Gait state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      swing_q     <= 1'b0;
      old_swing_q <= 1'b0;
      idx_q       <= '0;
      start_q     <= '0;
      end_q       <= 17'd32768;
      started_q   <= 1'b0;
      push_q      <= 1'b0;
      lift_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        held_q[i] <= '0;
        goal_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      swing_q     <= swing_d;
      old_swing_q <= old_swing_d;
      idx_q       <= idx_d;
      start_q     <= start_d;
      end_q       <= end_d;
      started_q   <= started_d;
      push_q      <= push_d;
      lift_q      <= lift_d;
      held_q      <= held_d;
      goal_q      <= goal_d;
    end
  end

  // Hold the request and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) req_q <= req_i;
    if (cmd_i.load_out) begin
      rsp_q.in_swing        <= swing_q;
      rsp_q.progress        <= quot;
      rsp_q.target_x        <= held_q[0];
      rsp_q.target_y        <= held_q[1];
      rsp_q.target_z        <= held_q[2];
      rsp_q.pushing_down    <= push_q;
      rsp_q.lift_height     <= lift_q;
      rsp_q.predicted_swing <= pred;
      rsp_q.phase_out       <= phase_q;
    end
  end

  assign sts_o.mode     = req_q.mode;
  assign sts_o.swing    = swing_q;
  assign sts_o.div_done = div_done;
  assign rsp_o          = rsp_q;

endmodule

/* src/lgcf_ctrl.sv */
// Controller: sequences one request through update, divide and result steps.
`timescale 1ns / 1ps
module lgcf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  lgcf_pkg::sts_t sts_i,
  output lgcf_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_DS1   = 8'b0000_0100,
    S_DW1   = 8'b0000_1000,
    S_TICK2 = 8'b0001_0000,
    S_DS2   = 8'b0010_0000,
    S_DW2   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.mode) begin
          cmd_o.restart = 1'b1;
          state_d       = S_DS2;
        end else begin
          cmd_o.tick_a = 1'b1;
          state_d      = sts_i.swing ? S_DS1 : S_TICK2;
        end
      end
      S_DS1: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DW1;
      end
      S_DW1: if (sts_i.div_done) state_d = S_TICK2;
      S_TICK2: begin
        cmd_o.tick_b = 1'b1;
        state_d      = S_DS2;
      end
      S_DS2: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DW2;
      end
      S_DW2: if (sts_i.div_done) state_d = S_FIN;
      S_FIN: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

/* src/leg_gait_contact_fsm.sv */
// Top level of the per-leg stance/swing gait scheduler.
//
// Usage:
//   One request per control tick on the input channel (valid/stall); one result
//   per request on the output channel (valid/stall), in order.
//   mode=0 advances the gait phase one tick; mode=1 restarts the pattern.
//   Configuration registers must be written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   only while the block is idle (the block does not enforce it); writes take effect at once.
// Sequence:
//   A stance tick runs one progress divide, a swing tick runs two and a restart
//   runs one; a zero, negative or full progress fraction skips a divider run.
//   One request is in flight at a time and the next is taken only after the
//   result loads and the controller returns to idle; the serial progress
//   divider, run once or twice per request, sets this pace.
// Reset:
//   rst_ni clears the gait state to stance at phase zero and loads the register
//   defaults. No clearing pass is needed.
// Stall:
//   A finished result holds in the output register while out_stall_i is high;
//   the next request may be accepted and worked on meanwhile, and it waits to
//   load until the output register frees.
`timescale 1ns / 1ps
module leg_gait_contact_fsm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lgcf_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lgcf_pkg::rsp_t out_rsp_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [16:0]    cfg_wdata_i
);

  lgcf_pkg::cmd_t cmd;
  lgcf_pkg::sts_t sts;

  lgcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lgcf_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (out_rsp_o)
  );

endmodule

/* verif/leg_gait_contact_fsm_tb.sv */
// Testbench for the leg gait contact scheduler: predicts each result and checks it.
`timescale 1ns / 1ps
module leg_gait_contact_fsm_tb;

  localparam int unsigned LimitCycles = 1000000;
  localparam logic signed [63:0] Floor64 = -64'sd26214;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  lgcf_pkg::req_t in_req_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  lgcf_pkg::rsp_t out_rsp_o;
  logic           cfg_we_i = 1'b0;
  logic [2:0]     cfg_idx_i = '0;
  logic [16:0]    cfg_wdata_i = '0;

  leg_gait_contact_fsm dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow registers
  logic [16:0] sh_step, sh_st [4];
  logic [2:0]  sh_len;
  logic [3:0]  sh_pat;
  logic [15:0] sh_push;

  // Shadow gait state
  logic [17:0] g_phase;
  logic        g_swing, g_started;
  logic [1:0]  g_idx;
  logic [16:0] g_start, g_end;
  logic signed [63:0] g_held [3], g_orig [3], g_goal [3], g_lift;

  lgcf_pkg::rsp_t expected_q [$];
  bit   failed = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int unsigned cycle_cnt = 0;

  function automatic int unsigned eff_len();
    int unsigned n;
    n = sh_len;
    if (n < 1) n = 1;
    if (n > lgcf_pkg::PatternLimit) n = lgcf_pkg::PatternLimit;
    return n;
  endfunction

  function automatic longint unsigned eff_step();
    return (sh_step > lgcf_pkg::OneQ16) ? 65536 : sh_step;
  endfunction

  function automatic logic [16:0] gait_progress();
    longint num, den, an, ad;
    num = longint'(g_phase) - longint'(g_start);
    den = longint'(g_end) - longint'(g_start);
    if (den == 0) return lgcf_pkg::OneQ16;
    if (num == 0 || ((num < 0) != (den < 0))) return '0;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an >= ad) return lgcf_pkg::OneQ16;
    return 17'((an * 65536) / ad);
  endfunction

  function automatic void advance_segment();
    g_idx = 2'((g_idx + 1) % eff_len());
    g_start = (g_phase > 65536) ? 17'(g_phase - 65536) : 17'(g_phase);
    g_end = sh_st[g_idx];
  endfunction

  function automatic logic predict_swing();
    longint unsigned p;
    p = g_phase + eff_step();
    if (p > 65536) p -= 65536;
    for (int i = 0; i < eff_len(); i++) begin
      if (p <= sh_st[i]) return sh_pat[i];
    end
    return 1'b0;
  endfunction

  function automatic void gait_reset();
    sh_step = 17'd328; sh_len = 3'd2; sh_pat = 4'd2;
    sh_st[0] = 17'd32768; sh_st[1] = lgcf_pkg::OneQ16;
    sh_st[2] = lgcf_pkg::OneQ16; sh_st[3] = lgcf_pkg::OneQ16;
    sh_push = 16'd33;
    g_phase = '0; g_swing = 1'b0; g_idx = '0; g_start = '0; g_end = sh_st[0];
    g_started = 1'b0; g_lift = 0;
    for (int i = 0; i < 3; i++) begin
      g_held[i] = 0; g_orig[i] = 0; g_goal[i] = 0;
    end
  endfunction

  // Predict the result of one request and advance the shadow state
  function automatic lgcf_pkg::rsp_t gait_tick(lgcf_pkg::req_t r);
    lgcf_pkg::rsp_t o;
    logic signed [63:0] ft [3], gl [3];
    logic [16:0] p;
    logic push;
    push = 1'b0;
    ft[0] = r.foot_x; ft[1] = r.foot_y; ft[2] = r.foot_z;
    gl[0] = r.goal_x; gl[1] = r.goal_y; gl[2] = r.goal_z;
    if (r.mode) begin
      g_phase = '0; g_idx = '0; g_start = '0; g_end = sh_st[0];
      if (g_swing) for (int i = 0; i < 3; i++) g_held[i] = g_goal[i];
      g_swing = sh_pat[0];
      g_started = 1'b0;
    end else begin
      if (!g_started) begin
        for (int i = 0; i < 3; i++) begin
          g_orig[i] = ft[i]; g_goal[i] = gl[i]; g_held[i] = gl[i];
        end
        g_started = 1'b1;
      end
      g_phase = 18'(g_phase + eff_step());
      if (!g_swing) begin
        if (g_phase >= g_end) begin
          g_lift = ft[2];
          advance_segment();
          for (int i = 0; i < 3; i++) g_orig[i] = ft[i];
          g_swing = 1'b1;
        end
      end else begin
        p = gait_progress();
        if ((p > lgcf_pkg::EarlyQ16 && r.contact) || p >= lgcf_pkg::OneQ16) begin
          g_swing = 1'b0;
          advance_segment();
          for (int i = 0; i < 3; i++) g_held[i] = ft[i];
        end
      end
      if (g_phase > 65536) g_phase = '0;
      if (!g_swing) begin
        if (!r.contact && g_held[2] > Floor64) begin
          g_held[2] = g_held[2] - longint'(sh_push);
          g_held[2] = longint'($signed(g_held[2][31:0]));
          push = 1'b1;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          g_goal[i] = gl[i]; g_held[i] = gl[i];
        end
      end
    end
    o.in_swing = g_swing;
    o.progress = gait_progress();
    o.target_x = g_held[0][31:0];
    o.target_y = g_held[1][31:0];
    o.target_z = g_held[2][31:0];
    o.pushing_down = push;
    o.lift_height = g_lift[31:0];
    o.predicted_swing = predict_swing();
    o.phase_out = g_phase;
    return o;
  endfunction

  // Send one request and hold it until accepted
  task automatic send_request(lgcf_pkg::req_t r);
    lgcf_pkg::rsp_t exp_r;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    exp_r = gait_tick(r);
    expected_q = {expected_q, exp_r};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop the request line and wait for every result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      lgcf_pkg::RegPhaseStep:     sh_step = val;
      lgcf_pkg::RegPatternLength: sh_len = val[2:0];
      lgcf_pkg::RegPatternStates: sh_pat = val[3:0];
      lgcf_pkg::RegSwitchTime0:   sh_st[0] = val;
      lgcf_pkg::RegSwitchTime1:   sh_st[1] = val;
      lgcf_pkg::RegSwitchTime2:   sh_st[2] = val;
      lgcf_pkg::RegSwitchTime3:   sh_st[3] = val;
      lgcf_pkg::RegPushStep:      sh_push = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(32'hFFFF_999A + $urandom_range(2, 0) - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic lgcf_pkg::req_t rand_request(int restart_pct);
    lgcf_pkg::req_t r;
    r.mode = ($urandom_range(99, 0) < restart_pct);
    r.foot_x = rand_pos(); r.foot_y = rand_pos(); r.foot_z = rand_pos();
    r.goal_x = rand_pos(); r.goal_y = rand_pos(); r.goal_z = rand_pos();
    r.contact = 1'($urandom_range(1, 0));
    return r;
  endfunction

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    lgcf_pkg::rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_rsp_o);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (e !== out_rsp_o) begin
          $display("%0t: mismatch, expected %p actual %p", $time, e, out_rsp_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Drive receiver stalls
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
  end

  // End the run on a hung block
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    lgcf_pkg::req_t r;
    r = '0;
    r.goal_x = 32'h7FFF_FFFF; r.goal_y = 32'h8000_0000; r.goal_z = 32'h0001_0000;
    r.foot_x = 32'h8000_0000; r.foot_y = 32'h7FFF_FFFF; r.foot_z = 32'hFFFF_999B;
    send_request(r);
    for (int i = 0; i < 8; i++) begin
      r.contact = i[0];
      send_request(r);
    end
    r.mode = 1'b1;
    send_request(r);
    r.mode = 1'b0;
    r.contact = 1'b0;
    send_request(r);
    wait_idle();
    // Fast stepping crosses every segment end, wraps and sees early contact
    write_reg(lgcf_pkg::RegPhaseStep, 17'd20000);
    write_reg(lgcf_pkg::RegPushStep, 17'h0FFFF);
    for (int i = 0; i < 12; i++) begin
      r = rand_request(0);
      send_request(r);
    end
    wait_idle();
  endtask

  task automatic random_config();
    int k;
    k = $urandom_range(9, 0);
    write_reg(lgcf_pkg::RegPhaseStep, k == 0 ? 17'd0 : k == 1 ? 17'h1FFFF :
              k == 2 ? lgcf_pkg::OneQ16 : 17'($urandom_range(12000, 500)));
    write_reg(lgcf_pkg::RegPatternLength, 17'($urandom_range(7, 0)));
    write_reg(lgcf_pkg::RegPatternStates, 17'($urandom_range(15, 0)));
    for (int i = 0; i < 4; i++) begin
      k = $urandom_range(7, 0);
      write_reg(3'(lgcf_pkg::RegSwitchTime0 + i), k == 0 ? 17'd0 :
                k == 1 ? lgcf_pkg::OneQ16 :
                k == 2 ? 17'h1FFFF : 17'($urandom_range(65536, 0)));
    end
    write_reg(lgcf_pkg::RegPushStep, $urandom_range(1, 0) ?
              17'($urandom_range(65535, 0)) : 17'($urandom_range(40, 0)));
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      random_config();
      for (int i = 0; i < per_phase; i++) begin
        send_request(rand_request(3));
        // Hold off until all results drain
        if (i == per_phase / 2 && ph == 1) wait_idle();
      end
      wait_idle();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    gait_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(24, 75);
    wait_idle();
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* leg_gait_contact_fsm.f */
src/lgcf_pkg.sv
src/lgcf_div.sv
src/lgcf_datapath.sv
src/lgcf_ctrl.sv
src/leg_gait_contact_fsm.sv
verif/leg_gait_contact_fsm_tb.sv
